/* rtl/bmsi_pkg.sv */
// Package for the bank mapper with scanline interrupt.
// Holds widths, decoded write addresses, the control struct and bank reset values.
// No dependencies.
package bmsi_pkg;

    // Field widths
    localparam int unsigned AddrW   = 16;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned VramW   = 14;
    localparam int unsigned CycleW  = 32;
    localparam int unsigned NumBank = 8;
    localparam int unsigned BankIdxW = $clog2(NumBank);

    // Stream payload widths (padded to whole bytes)
    localparam int unsigned InDataW  = 72;
    localparam int unsigned OutDataW = 72;

    // Address decode and bit positions
    localparam logic [AddrW-1:0] ADDR_MASK    = 16'hE003;
    localparam logic [ByteW-1:0] LATCH_INVERT = 8'hFF;
    localparam int unsigned      A12_POS      = 12;
    localparam logic [CycleW-1:0] MIN_EDGE_GAP = 32'd16;
    localparam int unsigned      MIRROR_POS   = 6;

    // Decoded register addresses
    localparam logic [AddrW-1:0] REG_PRG_8000  = 16'h8000;
    localparam logic [AddrW-1:0] REG_PRG_A000  = 16'h8001;
    localparam logic [AddrW-1:0] REG_CHR_0000  = 16'h8002;
    localparam logic [AddrW-1:0] REG_CHR_0800  = 16'h8003;
    localparam logic [AddrW-1:0] REG_CHR_1000  = 16'hA000;
    localparam logic [AddrW-1:0] REG_CHR_1400  = 16'hA001;
    localparam logic [AddrW-1:0] REG_CHR_1800  = 16'hA002;
    localparam logic [AddrW-1:0] REG_CHR_1C00  = 16'hA003;
    localparam logic [AddrW-1:0] REG_IRQ_LATCH = 16'hC000;
    localparam logic [AddrW-1:0] REG_IRQ_CLEAR = 16'hC001;
    localparam logic [AddrW-1:0] REG_IRQ_EN    = 16'hC002;
    localparam logic [AddrW-1:0] REG_IRQ_DIS   = 16'hC003;
    localparam logic [AddrW-1:0] REG_MIRROR    = 16'hE000;

    // Request kinds
    localparam logic REQ_CPU = 1'b0;
    localparam logic REQ_PPU = 1'b1;

    // One registered input item
    typedef struct packed {
        logic              req_type;
        logic [AddrW-1:0]  cpu_address;
        logic [ByteW-1:0]  write_value;
        logic [VramW-1:0]  ppu_addr;
        logic [CycleW-1:0] ppu_cycle;
    } t_item;

    // Update controls from decode to the state block
    typedef struct packed {
        logic                bank_we;
        logic [BankIdxW-1:0] bank_idx;
        logic                latch_we;
        logic                cnt_clr;
        logic                irq_en_set;
        logic                irq_dis;
        logic                mirror_we;
        logic                a12_we;
        logic                a12_val;
        logic                edge_seen;
        logic                cnt_clk;
    } t_ctrl;

    // Result item
    typedef struct packed {
        logic                          irq_out;
        logic                          mirror_horiz;
        logic [NumBank-1:0][ByteW-1:0] banks;
    } t_result;

    // Bank register reset values, in output order
    function automatic logic [ByteW-1:0] bank_reset(input logic [BankIdxW-1:0] idx);
        logic [ByteW-1:0] v;
        unique case (idx)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd1;
            3'd2:    v = 8'd0;
            3'd3:    v = 8'd1;
            3'd4:    v = 8'd4;
            3'd5:    v = 8'd5;
            3'd6:    v = 8'd6;
            default: v = 8'd7;
        endcase
        return v;
    endfunction

endpackage

/* rtl/bmsi_decode.sv */
// Decoder for one registered item: CPU register selects and PPU A12 edge qualification.
// Depends on bmsi_pkg.
module bmsi_decode
    import bmsi_pkg::*;
(
    input  t_item              i_item,
    input  logic               i_last_a12,
    input  logic [CycleW-1:0]  i_last_edge_cycle,
    output t_ctrl              o_ctrl
);

    logic [AddrW-1:0]  sel;
    logic              a12;
    logic [CycleW-1:0] gap;

    assign sel = i_item.cpu_address & ADDR_MASK;
    assign a12 = i_item.ppu_addr[A12_POS];
    assign gap = i_item.ppu_cycle - i_last_edge_cycle;

    always_comb begin
        o_ctrl = '0;
        if (i_item.req_type == REQ_CPU) begin
            // CPU register write decode
            unique case (sel)
                REG_PRG_8000, REG_PRG_A000, REG_CHR_0000, REG_CHR_0800,
                REG_CHR_1000, REG_CHR_1400, REG_CHR_1800, REG_CHR_1C00: begin
                    o_ctrl.bank_we  = 1'b1;
                    o_ctrl.bank_idx = {sel[13], sel[1:0]};
                end
                REG_IRQ_LATCH: o_ctrl.latch_we   = 1'b1;
                REG_IRQ_CLEAR: o_ctrl.cnt_clr    = 1'b1;
                REG_IRQ_EN:    o_ctrl.irq_en_set = 1'b1;
                REG_IRQ_DIS:   o_ctrl.irq_dis    = 1'b1;
                REG_MIRROR:    o_ctrl.mirror_we  = 1'b1;
                default: ;
            endcase
        end else begin
            // PPU address change: rising A12, filtered by minimum gap
            o_ctrl.a12_we    = 1'b1;
            o_ctrl.a12_val   = a12;
            o_ctrl.edge_seen = a12 && !i_last_a12;
            o_ctrl.cnt_clk   = a12 && !i_last_a12 && (gap >= MIN_EDGE_GAP);
        end
    end

endmodule

/* rtl/bmsi_state.sv */
// Mapper state: bank registers, mirroring, IRQ latch/counter and A12 edge tracking.
// Depends on bmsi_pkg; takes controls from bmsi_decode.
module bmsi_state
    import bmsi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_ctrl              i_ctrl,
    input  logic [ByteW-1:0]   i_write_value,
    input  logic [CycleW-1:0]  i_ppu_cycle,
    output logic               o_last_a12,
    output logic [CycleW-1:0]  o_last_edge_cycle,
    output t_result            o_next_result
);

    logic [NumBank-1:0][ByteW-1:0] r_banks, n_banks;
    logic                          r_mirror, n_mirror;
    logic [ByteW-1:0]              r_reload, n_reload;
    logic [ByteW-1:0]              r_counter, n_counter;
    logic                          r_irq_en, n_irq_en;
    logic                          r_irq, n_irq;
    logic                          r_last_a12, n_last_a12;
    logic [CycleW-1:0]             r_last_edge, n_last_edge;

    // Next state for the item in the input register
    always_comb begin
        n_banks     = r_banks;
        n_mirror    = r_mirror;
        n_reload    = r_reload;
        n_counter   = r_counter;
        n_irq_en    = r_irq_en;
        n_irq       = r_irq;
        n_last_a12  = r_last_a12;
        n_last_edge = r_last_edge;
        if (i_advance) begin
            if (i_ctrl.bank_we) begin
                n_banks[i_ctrl.bank_idx] = i_write_value;
            end
            if (i_ctrl.latch_we) begin
                n_reload = i_write_value ^ LATCH_INVERT;
            end
            if (i_ctrl.cnt_clr) begin
                n_counter = '0;
            end
            if (i_ctrl.irq_en_set) begin
                n_irq_en = 1'b1;
            end
            if (i_ctrl.irq_dis) begin
                n_irq_en = 1'b0;
                n_irq    = 1'b0;
            end
            if (i_ctrl.mirror_we) begin
                n_mirror = i_write_value[MIRROR_POS];
            end
            if (i_ctrl.a12_we) begin
                n_last_a12 = i_ctrl.a12_val;
            end
            if (i_ctrl.edge_seen) begin
                n_last_edge = i_ppu_cycle;
            end
            // Scanline counter: reload at zero, else count down
            if (i_ctrl.cnt_clk) begin
                n_counter = (r_counter == '0) ? r_reload : r_counter - 1'b1;
                if (r_irq_en && (n_counter == '0)) begin
                    n_irq = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumBank; i++) begin
                r_banks[i] <= bank_reset(BankIdxW'(i));
            end
            r_mirror    <= 1'b0;
            r_reload    <= '0;
            r_counter   <= '0;
            r_irq_en    <= 1'b0;
            r_irq       <= 1'b0;
            r_last_a12  <= 1'b0;
            r_last_edge <= '0;
        end else begin
            r_banks     <= n_banks;
            r_mirror    <= n_mirror;
            r_reload    <= n_reload;
            r_counter   <= n_counter;
            r_irq_en    <= n_irq_en;
            r_irq       <= n_irq;
            r_last_a12  <= n_last_a12;
            r_last_edge <= n_last_edge;
        end
    end

    assign o_last_a12                 = r_last_a12;
    assign o_last_edge_cycle          = r_last_edge;
    assign o_next_result.banks        = n_banks;
    assign o_next_result.mirror_horiz = n_mirror;
    assign o_next_result.irq_out      = n_irq;

endmodule

/* rtl/bank_mapper_with_scanline_irq.sv */
// Channel | Dir | Signals                                 | Content
// s       | in  | i_s_tvalid, o_s_tready, i_s_tdata, i_s_tuser | CPU write or PPU address change
// m       | out | o_m_tvalid, i_m_tready, o_m_tdata        | bank map, mirroring, IRQ line
//
// Every item yields one result: it is held in the input register, then decode and state
// update write the result register.
// One item per cycle sustained while the result side accepts; the input side stays ready while a result waits,
// as long as the input register is empty or moving on.
// Synchronous active-low reset clears the handshake and all mapper state.
// Top level; depends on bmsi_pkg, bmsi_decode and bmsi_state.
module bank_mapper_with_scanline_irq
    import bmsi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [15:0] cpu_address, [23:16] write_value, [37:24] ppu_addr,
    // [69:38] ppu_cycle, [71:70] zero
    input  logic [InDataW-1:0]  i_s_tdata,
    // [0] req_type
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [7:0] prg_bank_8000, [15:8] prg_bank_a000, [23:16] chr_bank_0000,
    // [31:24] chr_bank_0800, [39:32] chr_bank_1000, [47:40] chr_bank_1400,
    // [55:48] chr_bank_1800, [63:56] chr_bank_1c00, [64] mirror_horiz,
    // [65] irq_out, [71:66] zero
    output logic [OutDataW-1:0] o_m_tdata
);

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    t_ctrl             ctrl;
    logic              last_a12;
    logic [CycleW-1:0] last_edge_cycle;
    t_result           next_result;

    // Pipeline handshake
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.req_type    <= i_s_tuser;
            r_item.cpu_address <= i_s_tdata[15:0];
            r_item.write_value <= i_s_tdata[23:16];
            r_item.ppu_addr    <= i_s_tdata[37:24];
            r_item.ppu_cycle   <= i_s_tdata[69:38];
        end
    end

    bmsi_decode u_decode (
        .i_item            (r_item),
        .i_last_a12        (last_a12),
        .i_last_edge_cycle (last_edge_cycle),
        .o_ctrl            (ctrl)
    );

    bmsi_state u_state (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_ctrl            (ctrl),
        .i_write_value     (r_item.write_value),
        .i_ppu_cycle       (r_item.ppu_cycle),
        .o_last_a12        (last_a12),
        .o_last_edge_cycle (last_edge_cycle),
        .o_next_result     (next_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.irq_out, r_out.mirror_horiz, r_out.banks};

endmodule

/* dv/bank_mapper_with_scanline_irq_test.sv */
// Self-checking testbench for bank_mapper_with_scanline_irq: CPU writes and PPU bus events
// in, bank map / mirroring / IRQ line out, checked against an in-bench mapper model.
// Depends on bmsi_pkg and the mapper RTL.
module bank_mapper_with_scanline_irq_test;
    import bmsi_pkg::*;

    localparam int RANDOM_EVENTS = 1600;
    localparam int CALM_TAIL     = 150;    // last events sent with no random gaps or sink stalls
    localparam int DRAIN_EVERY   = 397;    // sender waits for all results before these
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [AddrW-1:0] ALIAS_BITS = ~ADDR_MASK;
    localparam logic [NumBank-1:0][ByteW-1:0] BANK_INIT =
        {8'd7, 8'd6, 8'd5, 8'd4, 8'd1, 8'd0, 8'd1, 8'd0};

    // One bus event as queued for the driver
    typedef struct {
        logic              kind;
        logic [AddrW-1:0]  addr;
        logic [ByteW-1:0]  value;
        logic [VramW-1:0]  vram;
        logic [CycleW-1:0] cycle;
        logic              drain;
    } t_bus_event;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [InDataW-1:0]  i_s_tdata = '0;
    logic                i_s_tuser = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OutDataW-1:0] o_m_tdata;

    t_bus_event bus_events[$];
    t_result    map_expected[$];
    int         n_accepted = 0;
    int         n_results = 0;
    int         mismatches = 0;
    logic       calm = 1'b0;
    int         src_gap = 0;
    int         sink_stall = 0;

    // Mapper model state
    logic [NumBank-1:0][ByteW-1:0] m_banks;
    logic                          m_mirror;
    logic [ByteW-1:0]              m_reload;
    logic [ByteW-1:0]              m_count;
    logic                          m_irq_en;
    logic                          m_irq;
    logic                          m_last_a12;
    logic [CycleW-1:0]             m_last_edge;

    // Stimulus generator state
    logic [CycleW-1:0] ppu_now;
    logic              a12_now;

    bank_mapper_with_scanline_irq dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advance the mapper model by one bus event and return the resulting map
    function automatic t_result mapper_step(input logic kind, input logic [AddrW-1:0] addr,
                                            input logic [ByteW-1:0] value,
                                            input logic [VramW-1:0] vram,
                                            input logic [CycleW-1:0] cycle);
        logic [AddrW-1:0]  sel;
        logic [CycleW-1:0] gap;
        t_result           res;
        if (kind == REQ_PPU) begin
            // rising A12 edge clocks the counter unless it follows the last edge too soon
            if (vram[A12_POS] && !m_last_a12) begin
                gap = cycle - m_last_edge;
                if (gap >= MIN_EDGE_GAP) begin
                    if (m_count == 0)
                        m_count = m_reload;
                    else
                        m_count = m_count - 8'd1;
                    if (m_irq_en && m_count == 0)
                        m_irq = 1'b1;
                end
                m_last_edge = cycle;
            end
            m_last_a12 = vram[A12_POS];
        end else begin
            sel = addr & ADDR_MASK;
            case (sel)
                REG_PRG_8000, REG_PRG_A000, REG_CHR_0000, REG_CHR_0800: begin
                    m_banks[{1'b0, sel[1:0]}] = value;
                end
                REG_CHR_1000, REG_CHR_1400, REG_CHR_1800, REG_CHR_1C00: begin
                    m_banks[{1'b1, sel[1:0]}] = value;
                end
                REG_IRQ_LATCH: m_reload = value ^ LATCH_INVERT;
                REG_IRQ_CLEAR: m_count = '0;
                REG_IRQ_EN:    m_irq_en = 1'b1;
                REG_IRQ_DIS: begin
                    m_irq_en = 1'b0;
                    m_irq    = 1'b0;
                end
                REG_MIRROR:    m_mirror = value[MIRROR_POS];
                default: ;
            endcase
        end
        res.banks        = m_banks;
        res.mirror_horiz = m_mirror;
        res.irq_out      = m_irq;
        return res;
    endfunction

    // CPU write with random don't-care PPU fields
    function automatic t_bus_event cpu_wr(input logic [AddrW-1:0] addr,
                                          input logic [ByteW-1:0] value);
        t_bus_event ev;
        ev.kind  = REQ_CPU;
        ev.addr  = addr;
        ev.value = value;
        ev.vram  = VramW'($urandom);
        ev.cycle = $urandom;
        ev.drain = 1'b0;
        return ev;
    endfunction

    // PPU address change with random don't-care CPU fields
    function automatic t_bus_event ppu_ev(input logic [VramW-1:0] vram,
                                          input logic [CycleW-1:0] cycle);
        t_bus_event ev;
        ev.kind  = REQ_PPU;
        ev.addr  = AddrW'($urandom);
        ev.value = ByteW'($urandom);
        ev.vram  = vram;
        ev.cycle = cycle;
        ev.drain = 1'b0;
        return ev;
    endfunction

    // Random PPU address with A12 forced
    function automatic logic [VramW-1:0] vram_with_a12(input logic a12);
        logic [VramW-1:0] v;
        v = VramW'($urandom);
        v[A12_POS] = a12;
        return v;
    endfunction

    // Random CPU write, mostly to decoded registers through random alias bits
    function automatic t_bus_event random_cpu_wr();
        logic [AddrW-1:0] addr;
        logic [ByteW-1:0] value;
        logic [AddrW-1:0] reg_sel;
        logic [1:0]       low;
        int               pick;
        value = ByteW'($urandom);
        pick  = $urandom_range(0, 15);
        low   = 2'($urandom);
        if (pick <= 5)
            reg_sel = ($urandom_range(0, 1) ? REG_PRG_8000 : REG_CHR_1000) | low;
        else if (pick <= 7) begin
            reg_sel = REG_IRQ_LATCH;
            if ($urandom_range(0, 1))
                value = LATCH_INVERT - ByteW'($urandom_range(0, 5));
        end else if (pick == 8)
            reg_sel = REG_IRQ_CLEAR;
        else if (pick <= 10)
            reg_sel = REG_IRQ_EN;
        else if (pick == 11)
            reg_sel = REG_IRQ_DIS;
        else if (pick <= 13)
            reg_sel = REG_MIRROR;
        else if (pick == 14)
            reg_sel = REG_MIRROR | (low == 2'd0 ? 2'd1 : low);    // undecoded E001..E003
        else
            reg_sel = 16'h0000;
        if (pick == 15)
            addr = AddrW'($urandom_range(0, 16'h7FFF));            // below the mapper window
        else
            addr = (ALIAS_BITS & AddrW'($urandom)) | reg_sel;
        return cpu_wr(addr, value);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // Driver: presents queued events, with random gaps and drain holds
    always @(posedge i_clk) begin : drive_proc
        logic fire;
        logic take;
        fire = i_s_tvalid && o_s_tready;
        take = 1'b0;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap    <= 0;
        end else begin
            calm <= (bus_events.size() < CALM_TAIL);
            if (fire || !i_s_tvalid) begin
                if (src_gap != 0)
                    src_gap <= src_gap - 1;
                else if (bus_events.size() != 0 &&
                         !(bus_events[0].drain && (fire || n_accepted != n_results)))
                    take = 1'b1;
                if (take) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= bus_events[0].kind;
                    i_s_tdata  <= {2'b00, bus_events[0].cycle, bus_events[0].vram,
                                   bus_events[0].value, bus_events[0].addr};
                    void'(bus_events.pop_front());
                    if (!calm && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 16);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side backpressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            sink_stall <= $urandom_range(0, 15);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Monitor: check each result transaction, then predict each accepted event
    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_results <= n_results + 1;
                got = o_m_tdata[$bits(t_result)-1:0];
                if (map_expected.size() == 0) begin
                    flag_mismatch($sformatf("result %h with nothing expected", got));
                end else begin
                    want = map_expected.pop_front();
                    for (int i = 0; i < NumBank; i++) begin
                        if (got.banks[i] !== want.banks[i])
                            flag_mismatch($sformatf("bank %0d exp %h got %h",
                                                    i, want.banks[i], got.banks[i]));
                    end
                    if (got.mirror_horiz !== want.mirror_horiz)
                        flag_mismatch($sformatf("mirror exp %b got %b",
                                                want.mirror_horiz, got.mirror_horiz));
                    if (got.irq_out !== want.irq_out)
                        flag_mismatch($sformatf("irq exp %b got %b",
                                                want.irq_out, got.irq_out));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                n_accepted <= n_accepted + 1;
                map_expected.push_back(mapper_step(i_s_tuser, i_s_tdata[15:0],
                                                   i_s_tdata[23:16], i_s_tdata[37:24],
                                                   i_s_tdata[69:38]));
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stim_proc
        t_bus_event ev;
        int         seg;
        int         n_random;
        m_banks     = BANK_INIT;
        m_mirror    = 1'b0;
        m_reload    = '0;
        m_count     = '0;
        m_irq_en    = 1'b0;
        m_irq       = 1'b0;
        m_last_a12  = 1'b0;
        m_last_edge = '0;

        // Directed: reset map, register extremes through aliases, counter corner cases
        bus_events.push_back(ppu_ev(14'h0FFF, 32'd4));                 // no edge
        bus_events.push_back(cpu_wr(REG_PRG_8000 | ALIAS_BITS, 8'hFF));
        bus_events.push_back(cpu_wr(REG_CHR_0000, 8'hA5));
        bus_events.push_back(cpu_wr(REG_CHR_0800 | ALIAS_BITS, 8'h5A));
        bus_events.push_back(cpu_wr(REG_CHR_1000, 8'h80));
        bus_events.push_back(cpu_wr(REG_CHR_1800 | ALIAS_BITS, 8'h7F));
        bus_events.push_back(cpu_wr(REG_CHR_1C00, 8'hFE));
        bus_events.push_back(cpu_wr(REG_MIRROR, 8'h40));               // horizontal
        bus_events.push_back(cpu_wr(REG_MIRROR | ALIAS_BITS, 8'hBF));  // back to vertical
        bus_events.push_back(cpu_wr(REG_IRQ_LATCH, 8'hFD));            // reload of 2
        bus_events.push_back(cpu_wr(REG_IRQ_EN, 8'h00));
        bus_events.push_back(ppu_ev(14'h1000, 32'd100));               // zero count reloads
        bus_events.push_back(ppu_ev(14'h0000, 32'd105));
        bus_events.push_back(ppu_ev(14'h3FFF, 32'd112));               // edge too soon
        bus_events.push_back(ppu_ev(14'h2FFF, 32'd120));
        bus_events.push_back(ppu_ev(14'h1000, 32'd128));               // gap exactly 16
        bus_events.push_back(ppu_ev(14'h0000, 32'd140));
        bus_events.push_back(ppu_ev(14'h1001, 32'd200));               // reaches zero, IRQ
        bus_events.push_back(ppu_ev(14'h1001, 32'd300));               // A12 held high
        bus_events.push_back(cpu_wr(REG_MIRROR | 16'h0003, 8'hFF));    // undecoded
        bus_events.push_back(cpu_wr(16'h7FFF, 8'hFF));                 // below window
        bus_events.push_back(cpu_wr(REG_IRQ_CLEAR, 8'h00));
        bus_events.push_back(cpu_wr(REG_IRQ_DIS, 8'h00));              // drops IRQ
        bus_events.push_back(ppu_ev(14'h0000, 32'hFFFF_FFF0));
        bus_events.push_back(ppu_ev(14'h1000, 32'hFFFF_FFF8));
        bus_events.push_back(ppu_ev(14'h0000, 32'h0000_0002));
        bus_events.push_back(ppu_ev(14'h1000, 32'h0000_0008));         // gap wraps to 16
        ppu_now = 32'd8;
        a12_now = 1'b1;

        // Random: mostly scanline-like A12 toggling with register traffic, some noise
        n_random = 0;
        while (n_random < RANDOM_EVENTS) begin
            seg = $urandom_range(0, 99);
            if (seg < 60) begin
                ppu_now = ppu_now + $urandom_range(1, 200);
                a12_now = ($urandom_range(0, 4) != 0) ? !a12_now : a12_now;
                ev = ppu_ev(vram_with_a12(a12_now), ppu_now);
            end else if (seg < 90) begin
                ev = random_cpu_wr();
            end else if (seg < 96) begin
                ppu_now = ppu_now + $urandom_range(0, 15);                // A12 toggles close together
                a12_now = !a12_now;
                ev = ppu_ev(vram_with_a12(a12_now), ppu_now);
            end else begin
                ppu_now = $urandom;
                ev = ppu_ev(VramW'($urandom), ppu_now);
                a12_now = ev.vram[A12_POS];
            end
            n_random++;
            ev.drain = (n_random % DRAIN_EVERY == 0);
            bus_events.push_back(ev);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_events.size() != 0 || i_s_tvalid || n_results != n_accepted)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && map_expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/bmsi_pkg.sv
rtl/bmsi_decode.sv
rtl/bmsi_state.sv
rtl/bank_mapper_with_scanline_irq.sv
dv/bank_mapper_with_scanline_irq_test.sv
